>>> sv/pvp_pkg.sv
// Shared types and constants for the perspective vertex projector.
package pvp_pkg;

    // Request kinds carried on the input tuser bit
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_VERTEX = 1'b1;

    // Camera word indexes
    localparam logic [3:0] IDX_ROT_FIRST = 4'd0;
    localparam logic [3:0] IDX_ROT_LAST  = 4'd8;
    localparam logic [3:0] IDX_POS_X     = 4'd9;
    localparam logic [3:0] IDX_POS_Y     = 4'd10;
    localparam logic [3:0] IDX_POS_Z     = 4'd11;

    // Fixed field widths
    localparam int PIX_W  = 11;
    localparam int WORD_W = 32;

    // Products issued on the shared multiplier per vertex
    localparam int MAC_STEPS = 9;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_CHECK,
        ST_DIV,
        ST_FIN
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic load;       // write a camera word, clear pen
        logic capture;    // latch vertex, form relative position
        logic mac_mul;    // issue one matrix product
        logic mac_acc;    // accumulate the previous product
        logic check;      // clip test and divider set-up
        logic div_step;   // one quotient bit for x and y
        logic finish;     // write result register, update pen
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic reject;     // clip test fails on current D
        logic out_free;   // result register can take a new result
    } t_stat;

endpackage

>>> sv/pvp_ctrl.sv
// Sequencer for camera loads and the vertex projection steps.
module pvp_ctrl #(
    parameter int DIV_STEPS = 10
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_tvalid,
    input  logic           i_op,
    output logic           o_s_tready,
    input  pvp_pkg::t_stat i_stat,
    output pvp_pkg::t_cmd  o_cmd
);
    import pvp_pkg::*;

    localparam int CNT_MAX = (DIV_STEPS > MAC_STEPS) ? DIV_STEPS : MAC_STEPS;
    localparam int CNT_W   = $clog2(CNT_MAX + 1);

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Next state and commands; no request is taken while reset is held
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_s_tready = i_rst_n;
                if (i_s_tvalid && i_rst_n) begin
                    if (i_op == OP_LOAD) begin
                        o_cmd.load = 1'b1;
                    end else begin
                        o_cmd.capture = 1'b1;
                        n_cnt         = '0;
                        n_state       = ST_MAC;
                    end
                end
            end
            ST_MAC: begin
                o_cmd.mac_mul = (r_cnt < CNT_W'(MAC_STEPS));
                o_cmd.mac_acc = (r_cnt != '0);
                n_cnt         = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(MAC_STEPS)) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                o_cmd.check = 1'b1;
                n_cnt       = '0;
                n_state     = i_stat.reject ? ST_FIN : ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTH
    a_finish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> i_stat.out_free)
        else $error("result written while result register busy");
    a_capture_mac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> (r_state == ST_MAC) && (r_cnt == '0))
        else $error("vertex capture not followed by matrix pass");
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.div_step && (o_cmd.mac_mul || o_cmd.mac_acc)))
        else $error("divider and multiplier active together");
    a_check_after_mac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.check |-> $past(r_state) == ST_MAC)
        else $error("clip test without a finished matrix pass");
`endif

endmodule

>>> sv/pvp_dp.sv
// Camera store, rotation MAC, clip test, dividers, pen and result register.
module pvp_dp #(
    parameter int COORD_WIDTH      = 32,
    parameter int MATRIX_FRAC_BITS = 16,
    parameter int SCREEN_SIZE      = 400
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pvp_pkg::t_cmd                 i_cmd,
    output pvp_pkg::t_stat                o_stat,
    input  logic [3:0]                    i_idx,
    input  logic signed [31:0]            i_word,
    input  logic signed [COORD_WIDTH-1:0] i_vx,
    input  logic signed [COORD_WIDTH-1:0] i_vy,
    input  logic signed [COORD_WIDTH-1:0] i_vz,
    input  logic                          i_m_tready,
    output logic                          o_m_tvalid,
    output logic [1:0]                    o_m_tuser,
    output logic [47:0]                   o_m_tdata
);
    import pvp_pkg::*;

    localparam int RW   = MATRIX_FRAC_BITS + 2;
    localparam int EW   = COORD_WIDTH + 1;
    localparam int PW   = RW + EW;
    localparam int DW   = PW + 2;
    localparam int SSW  = $clog2(SCREEN_SIZE + 1) + 1;
    localparam int NW   = DW + SSW + 1;
    localparam int QW   = $clog2(3 * SCREEN_SIZE / 2 + 1);
    localparam logic signed [WORD_W-1:0] ROT_HI = WORD_W'((64'sd1 <<< (RW - 1)) - 1);
    localparam logic signed [WORD_W-1:0] ROT_LO = -ROT_HI - 1;
    localparam logic signed [NW-1:0] K_FULL = NW'(SCREEN_SIZE);
    localparam logic signed [NW-1:0] K_HALF = NW'(SCREEN_SIZE / 2);

    logic signed [RW-1:0]          r_rot [9];
    logic signed [COORD_WIDTH-1:0] r_cam [3];
    logic signed [EW-1:0]          r_rel [3];
    logic signed [DW-1:0]          r_d   [3];
    logic signed [PW-1:0]          r_prod;
    logic                          r_sum0;
    logic [1:0]                    r_row, r_col, r_prow;
    logic                          r_rej;
    logic                          r_negx, r_negy;
    logic [NW-1:0]                 r_remx, r_remy, r_dv;
    logic [QW-1:0]                 r_qx, r_qy;
    logic                          r_pen;
    logic signed [PIX_W-1:0]       r_lpx, r_lpy;
    logic                          r_ov;
    logic [1:0]                    r_tuser;
    logic [47:0]                   r_tdata;

    logic signed [WORD_W-1:0] w_sat;
    logic [3:0]               w_ent;
    logic signed [DW:0]       w_d0, w_a1, w_a2;
    logic                     w_rej;
    logic signed [NW-1:0]     w_nx, w_ny;
    logic signed [QW:0]       w_sqx, w_sqy;
    logic signed [PIX_W-1:0]  w_px, w_py;

    // Rotation entry saturation
    always_comb begin
        if (i_word > ROT_HI) begin
            w_sat = ROT_HI;
        end else if (i_word < ROT_LO) begin
            w_sat = ROT_LO;
        end else begin
            w_sat = i_word;
        end
    end

    // Matrix entry for the current row and column
    assign w_ent = 4'({r_row, 1'b0}) + 4'(r_row) + 4'(r_col);

    // Clip test on D
    always_comb begin
        w_d0  = (DW+1)'(r_d[0]);
        w_a1  = r_d[1][DW-1] ? -(DW+1)'(r_d[1]) : (DW+1)'(r_d[1]);
        w_a2  = r_d[2][DW-1] ? -(DW+1)'(r_d[2]) : (DW+1)'(r_d[2]);
        w_rej = r_sum0 || (w_d0 < w_a1) || (w_d0 < w_a2) || (r_d[0] == '0);
    end

    // Projection numerators
    assign w_nx = NW'(r_d[1]) * K_FULL + NW'(r_d[0]) * K_HALF;
    assign w_ny = NW'(r_d[2]) * K_FULL + NW'(r_d[0]) * K_HALF;

    // Signed quotients, wrapped to pixel width
    assign w_sqx = r_negx ? -$signed({1'b0, r_qx}) : $signed({1'b0, r_qx});
    assign w_sqy = r_negy ? -$signed({1'b0, r_qy}) : $signed({1'b0, r_qy});
    assign w_px  = PIX_W'(w_sqx);
    assign w_py  = PIX_W'(w_sqy);

    assign o_stat.reject   = w_rej;
    assign o_stat.out_free = !r_ov || i_m_tready;

    // Camera store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 9; i++) r_rot[i] <= '0;
            for (int i = 0; i < 3; i++) r_cam[i] <= '0;
        end else if (i_cmd.load) begin
            case (i_idx) inside
                [IDX_ROT_FIRST:IDX_ROT_LAST]: r_rot[i_idx] <= RW'(w_sat);
                IDX_POS_X: r_cam[0] <= COORD_WIDTH'(i_word);
                IDX_POS_Y: r_cam[1] <= COORD_WIDTH'(i_word);
                IDX_POS_Z: r_cam[2] <= COORD_WIDTH'(i_word);
                default: ;
            endcase
        end
    end

    // Relative position, matrix pass and dividers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_rel[0] <= EW'(i_vx) - EW'(r_cam[0]);
            r_rel[1] <= EW'(i_vy) - EW'(r_cam[1]);
            r_rel[2] <= EW'(i_vz) + EW'(r_cam[2]);
            r_sum0   <= ((COORD_WIDTH+2)'(i_vx) + (COORD_WIDTH+2)'(i_vy)
                         + (COORD_WIDTH+2)'(i_vz)) == '0;
            for (int i = 0; i < 3; i++) r_d[i] <= '0;
            r_row <= '0;
            r_col <= '0;
        end
        if (i_cmd.mac_mul) begin
            r_prod <= PW'(r_rot[w_ent]) * PW'(r_rel[r_col]);
            r_prow <= r_row;
            if (r_col == 2'd2) begin
                r_col <= '0;
                r_row <= r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
        if (i_cmd.mac_acc) begin
            r_d[r_prow] <= r_d[r_prow] + DW'(r_prod);
        end
        if (i_cmd.check) begin
            r_rej  <= w_rej;
            r_negx <= w_nx[NW-1];
            r_negy <= w_ny[NW-1];
            r_remx <= w_nx[NW-1] ? NW'(-w_nx) : NW'(w_nx);
            r_remy <= w_ny[NW-1] ? NW'(-w_ny) : NW'(w_ny);
            r_dv   <= NW'(r_d[0]) << (QW - 1);
            r_qx   <= '0;
            r_qy   <= '0;
        end
        // restoring division, one bit a cycle, shared divisor
        if (i_cmd.div_step) begin
            if (r_remx >= r_dv) begin
                r_remx <= r_remx - r_dv;
                r_qx   <= {r_qx[QW-2:0], 1'b1};
            end else begin
                r_qx   <= {r_qx[QW-2:0], 1'b0};
            end
            if (r_remy >= r_dv) begin
                r_remy <= r_remy - r_dv;
                r_qy   <= {r_qy[QW-2:0], 1'b1};
            end else begin
                r_qy   <= {r_qy[QW-2:0], 1'b0};
            end
            r_dv <= r_dv >> 1;
        end
    end

    // Pen
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pen <= 1'b0;
            r_lpx <= '0;
            r_lpy <= '0;
        end else if (i_cmd.load) begin
            r_pen <= 1'b0;
        end else if (i_cmd.finish) begin
            r_pen <= !r_rej;
            if (!r_rej) begin
                r_lpx <= w_px;
                r_lpy <= w_py;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.finish) begin
            r_ov <= 1'b1;
        end else if (i_m_tready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            if (r_rej) begin
                r_tuser <= '0;
                r_tdata <= '0;
            end else if (r_pen) begin
                r_tuser <= 2'b11;
                r_tdata <= {4'b0, w_py, w_px, r_lpy, r_lpx};
            end else begin
                r_tuser <= 2'b01;
                r_tdata <= {4'b0, w_py, w_px, 22'b0};
            end
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tuser  = r_tuser;
    assign o_m_tdata  = r_tdata;

endmodule

>>> sv/perspective_vertex_projector.sv
// Top level: camera transform and perspective projection of world vertices.
//
//  channel  dir  tdata (low bit up)                               tuser
//  s        in   word_index, word_value, vertex_x, _y, _z, pad    operation
//  m        out  start_px, start_py, end_px, end_py, pad          visible, draw_line
//
// A camera load is written from the idle state. A vertex runs from request to
// result through nine products on the one shared multiplier plus a drain
// step, a clip step, then x and y divided side by side one bit a cycle over
// Q quotient bits (10 at a 400 pixel screen). A rejected vertex skips the
// division.
// Reset is synchronous, active low, and clears camera, pen and handshakes;
// no request is taken while it is held.
// A result waiting on a stalled output blocks only the next vertex's final
// cycle; loads are still taken.
module perspective_vertex_projector #(
    parameter int COORD_WIDTH      = 32,
    parameter int MATRIX_FRAC_BITS = 16,
    parameter int SCREEN_SIZE      = 400
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_s_tvalid,
    output logic                                          o_s_tready,
    // word_index[3:0], word_value, vertex_x, vertex_y, vertex_z, zero pad
    input  logic [((36 + 3 * COORD_WIDTH + 7) / 8) * 8 - 1:0] i_s_tdata,
    // operation
    input  logic                                          i_s_tuser,
    output logic                                          o_m_tvalid,
    input  logic                                          i_m_tready,
    // start_px, start_py, end_px, end_py (11 bits each), zero pad
    output logic [47:0]                                   o_m_tdata,
    // visible, draw_line
    output logic [1:0]                                    o_m_tuser
);
    import pvp_pkg::*;

    localparam int QW  = $clog2(3 * SCREEN_SIZE / 2 + 1);
    localparam int VX0 = 36;
    localparam int VY0 = VX0 + COORD_WIDTH;
    localparam int VZ0 = VY0 + COORD_WIDTH;

    t_cmd  w_cmd;
    t_stat w_stat;

    pvp_ctrl #(
        .DIV_STEPS (QW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_op       (i_s_tuser),
        .o_s_tready (o_s_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    pvp_dp #(
        .COORD_WIDTH      (COORD_WIDTH),
        .MATRIX_FRAC_BITS (MATRIX_FRAC_BITS),
        .SCREEN_SIZE      (SCREEN_SIZE)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .i_idx      (i_s_tdata[3:0]),
        .i_word     ($signed(i_s_tdata[35:4])),
        .i_vx       ($signed(i_s_tdata[VX0 +: COORD_WIDTH])),
        .i_vy       ($signed(i_s_tdata[VY0 +: COORD_WIDTH])),
        .i_vz       ($signed(i_s_tdata[VZ0 +: COORD_WIDTH])),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tuser  (o_m_tuser),
        .o_m_tdata  (o_m_tdata)
    );

endmodule
